// File: rtl/gidbc_pkg.sv
// Package: constants, command and status types for the GTP-U inner destination byte counter.
package gidbc_pkg;

   localparam int TABLE_ENTRIES       = 1024;
   localparam int TUNNEL_HEADER_BYTES = 16;
   localparam int IDX_W               = $clog2(TABLE_ENTRIES);
   localparam int CNT_W               = $clog2(TABLE_ENTRIES + 1);

   localparam int BYTE_W   = 8;
   localparam int KEY_W    = 16;
   localparam int LEN_W    = 16;
   localparam int PORT_W   = 16;
   localparam int TOTAL_W  = 64;
   localparam int STATUS_W = 3;

   localparam logic [LEN_W-1:0] ETH_TYPE_OFF    = 16'd12;
   localparam logic [LEN_W-1:0] UDP_DPORT_OFF   = 16'd36;
   localparam logic [LEN_W-1:0] INNER_DADDR_OFF = LEN_W'(42 + TUNNEL_HEADER_BYTES + 16);
   localparam logic [LEN_W-1:0] MIN_FRAME_LEN   = LEN_W'(42 + TUNNEL_HEADER_BYTES + 20);
   localparam logic [15:0]      IPV4_ETHERTYPE  = 16'h0800;
   localparam logic [PORT_W-1:0] TUNNEL_PORT_RESET = 16'd2152;

   typedef enum logic [STATUS_W-1:0] {
      STAT_COUNTED    = 3'd0,
      STAT_NOT_TUNNEL = 3'd1,
      STAT_FULL       = 3'd2,
      STAT_FOUND      = 3'd3,
      STAT_MISSING    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_READ,
      OP_NEXT,
      OP_REJECT,
      OP_HIT,
      OP_MISS
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic   accept;
      op_type op;
      logic   load;
   } cmd_type;

   typedef struct packed {
      logic job_query;
      logic job_tunnel;
      logic scan_end;
      logic match;
   } stat_type;

endpackage

// File: rtl/gidbc_dp.sv
// Datapath: header parser, flow table memory, scan index, result and output registers.
module gidbc_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [15:0]              csr_wr_data,
   input  logic                     req_mode,
   input  logic [7:0]               req_byte,
   input  logic                     req_last,
   input  logic [15:0]              req_query_key,
   input  gidbc_pkg::cmd_type       cmd,
   output gidbc_pkg::stat_type      stat,
   output logic [2:0]               rsp_status,
   output logic [15:0]              rsp_key,
   output logic [15:0]              rsp_len,
   output logic [63:0]              rsp_total
);
   import gidbc_pkg::*;

   logic [PORT_W-1:0]  port_cfg_ff;
   logic [LEN_W-1:0]   pos_ff, pos_inc;
   logic [15:0]        eth_ff, eth_in;
   logic [PORT_W-1:0]  port_ff, port_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic               tunnel_ok;

   logic               job_query_ff, job_tunnel_ff;
   logic [KEY_W-1:0]   job_key_ff;
   logic [LEN_W-1:0]   job_len_ff;

   logic [CNT_W-1:0]   used_ff, idx_ff;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [TOTAL_W-1:0] rd_total_ff;

   logic [KEY_W-1:0]   mem_key   [TABLE_ENTRIES];
   logic [TOTAL_W-1:0] mem_total [TABLE_ENTRIES];

   logic               full;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [TOTAL_W-1:0] wr_total, len_ext;

   status_type         res_status_ff;
   logic [KEY_W-1:0]   res_key_ff;
   logic [LEN_W-1:0]   res_len_ff;
   logic [TOTAL_W-1:0] res_total_ff;

   always_comb begin
      pos_inc = (pos_ff == '1) ? pos_ff : pos_ff + LEN_W'(1);
      eth_in  = eth_ff;
      port_in = port_ff;
      key_in  = key_ff;
      if (pos_ff == ETH_TYPE_OFF || pos_ff == ETH_TYPE_OFF + LEN_W'(1)) begin
         eth_in = {eth_ff[7:0], req_byte};
      end
      if (pos_ff == UDP_DPORT_OFF || pos_ff == UDP_DPORT_OFF + LEN_W'(1)) begin
         port_in = {port_ff[7:0], req_byte};
      end
      if (pos_ff == INNER_DADDR_OFF || pos_ff == INNER_DADDR_OFF + LEN_W'(1)) begin
         key_in = {key_ff[7:0], req_byte};
      end
      tunnel_ok = (pos_inc >= MIN_FRAME_LEN) && (eth_in == IPV4_ETHERTYPE) &&
                  (port_in == port_cfg_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_cfg_ff <= TUNNEL_PORT_RESET;
      end else if (csr_wr_en) begin
         port_cfg_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         eth_ff  <= '0;
         port_ff <= '0;
         key_ff  <= '0;
      end else if (cmd.accept && !req_mode) begin
         if (req_last) begin
            pos_ff  <= '0;
            eth_ff  <= '0;
            port_ff <= '0;
            key_ff  <= '0;
         end else begin
            pos_ff  <= pos_inc;
            eth_ff  <= eth_in;
            port_ff <= port_in;
            key_ff  <= key_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (req_mode) begin
            job_query_ff  <= 1'b1;
            job_tunnel_ff <= 1'b1;
            job_key_ff    <= req_query_key;
            job_len_ff    <= '0;
         end else if (req_last) begin
            job_query_ff  <= 1'b0;
            job_tunnel_ff <= tunnel_ok;
            job_key_ff    <= key_in;
            job_len_ff    <= pos_inc;
         end
      end
   end

   assign full    = (used_ff == CNT_W'(TABLE_ENTRIES));
   assign len_ext = TOTAL_W'(job_len_ff);

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = idx_ff[IDX_W-1:0];
      wr_total = rd_total_ff + len_ext;
      if (cmd.op == OP_HIT && !job_query_ff) begin
         wr_en = 1'b1;
      end else if (cmd.op == OP_MISS && !job_query_ff && !full) begin
         wr_en    = 1'b1;
         wr_addr  = used_ff[IDX_W-1:0];
         wr_total = len_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         idx_ff  <= '0;
      end else begin
         if (cmd.accept) begin
            idx_ff <= '0;
         end else if (cmd.op == OP_NEXT) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (cmd.op == OP_MISS && !job_query_ff && !full) begin
            used_ff <= used_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_READ) begin
         rd_key_ff   <= mem_key[idx_ff[IDX_W-1:0]];
         rd_total_ff <= mem_total[idx_ff[IDX_W-1:0]];
      end
      if (wr_en) begin
         mem_key[wr_addr]   <= job_key_ff;
         mem_total[wr_addr] <= wr_total;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_REJECT: begin
            res_status_ff <= STAT_NOT_TUNNEL;
            res_key_ff    <= '0;
            res_len_ff    <= job_len_ff;
            res_total_ff  <= '0;
         end
         OP_HIT: begin
            res_key_ff <= job_key_ff;
            res_len_ff <= job_len_ff;
            if (job_query_ff) begin
               res_status_ff <= STAT_FOUND;
               res_total_ff  <= rd_total_ff;
            end else begin
               res_status_ff <= STAT_COUNTED;
               res_total_ff  <= wr_total;
            end
         end
         OP_MISS: begin
            res_key_ff <= job_key_ff;
            res_len_ff <= job_len_ff;
            if (job_query_ff) begin
               res_status_ff <= STAT_MISSING;
               res_total_ff  <= '0;
            end else if (full) begin
               res_status_ff <= STAT_FULL;
               res_total_ff  <= '0;
            end else begin
               res_status_ff <= STAT_COUNTED;
               res_total_ff  <= wr_total;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status <= res_status_ff;
         rsp_key    <= res_key_ff;
         rsp_len    <= res_len_ff;
         rsp_total  <= res_total_ff;
      end
   end

   assign stat.job_query  = job_query_ff;
   assign stat.job_tunnel = job_tunnel_ff;
   assign stat.scan_end   = (idx_ff == used_ff);
   assign stat.match      = (rd_key_ff == job_key_ff);

`ifndef ASSERT_OFF
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_ENTRIES)) else $error("fill count past table size");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= used_ff) else $error("scan index past fill count");
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && used_ff != $past(used_ff)) |-> used_ff == $past(used_ff) + CNT_W'(1))
      else $error("fill count moved by other than one");
`endif

endmodule

// File: rtl/gidbc_ctrl.sv
// Controller: sequences byte intake, table scan, update and result handoff.
module gidbc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_mode,
   input  logic                  req_last,
   output logic                  req_tready,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   input  gidbc_pkg::stat_type   stat,
   output gidbc_pkg::cmd_type    cmd
);
   import gidbc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode || req_last)) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!stat.job_query && !stat.job_tunnel) state_in = ST_DONE;
            else state_in = ST_READ;
         end
         ST_READ: begin
            if (stat.scan_end) state_in = ST_DONE;
            else state_in = ST_CMP;
         end
         ST_CMP: begin
            if (stat.match) state_in = ST_DONE;
            else state_in = ST_READ;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.accept = accept;
      cmd.op     = OP_NONE;
      cmd.load   = 1'b0;
      case (state_ff)
         ST_CHECK: begin
            if (!stat.job_query && !stat.job_tunnel) cmd.op = OP_REJECT;
         end
         ST_READ: begin
            cmd.op = stat.scan_end ? OP_MISS : OP_READ;
         end
         ST_CMP: begin
            cmd.op = stat.match ? OP_HIT : OP_NEXT;
         end
         ST_DONE: begin
            cmd.load = slot_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = cmd.load || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_load_safe: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_tready)) else $error("beat overwritten");
   a_op_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cmd.op == OP_NONE && !cmd.load)) else $error("op while idle");
   a_done_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> $past(state_ff) != ST_IDLE) else $error("done without job");
`endif

endmodule

// File: rtl/gtpu_inner_dest_byte_counter.sv
// Top level: GTP-U inner destination byte counter, stream ports and CSR.
// Frame bytes are taken one per cycle while no job is in progress. A last byte of a
// tunnel frame or a query then scans the flow table, each of the N entries in use
// through a read state and a compare state (single-port table memory with a
// registered read); a non-tunnel frame skips the scan. The next beat is taken
// once the result sits in the output register. The table is empty right after
// reset: entries are allocated in order and tracked by a fill count, so no
// clearing pass runs.
module gtpu_inner_dest_byte_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // data_byte[7:0], query_key[23:8]
   input  logic        req_tuser,  // mode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // flow_key[15:0], frame_length[31:16], byte_total[95:32]
   output logic [2:0]  rsp_tuser   // status
);
   import gidbc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   gidbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_last   (req_tlast),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .stat       (stat),
      .cmd        (cmd)
   );

   gidbc_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_mode      (req_tuser),
      .req_byte      (req_tdata[7:0]),
      .req_last      (req_tlast),
      .req_query_key (req_tdata[23:8]),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_status    (rsp_tuser),
      .rsp_key       (rsp_tdata[15:0]),
      .rsp_len       (rsp_tdata[31:16]),
      .rsp_total     (rsp_tdata[95:32])
   );

endmodule
